### rtl/lmld_pkg.sv
// Shared types and constants for the label match line direction block.
// No dependencies.
`timescale 1ns / 1ps
package lmld_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_QUERY = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    typedef struct packed {
        logic        start;
        logic [14:0] a;
        logic [31:0] s;
    } t_ucmd;
endpackage

### rtl/lmld_unit.sv
// Bit-serial unit component: largest q with (2q-1)^2*s <= a^2*2^30.
// Each bit is found in two phases: square, then scale by s. Depends on lmld_pkg.
`timescale 1ns / 1ps
module lmld_unit import lmld_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ucmd       i_cmd,
    output logic        o_done,
    output logic [14:0] o_q
);
    logic [3:0]  r_bit;
    logic        r_busy, r_ph;
    logic [14:0] r_q;
    logic [29:0] r_a2;
    logic [31:0] r_s;
    logic [31:0] r_o2;
    logic [14:0] w_t;
    logic [15:0] w_o;
    logic [63:0] w_lhs;
    logic [63:0] w_rhs;

    assign w_t   = r_q | (15'd1 << r_bit);
    assign w_o   = {w_t, 1'b0} - 16'd1;
    assign w_lhs = {32'd0, r_o2} * {32'd0, r_s};
    assign w_rhs = {4'd0, r_a2, 30'd0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else if (i_cmd.start) begin
            r_busy <= 1'b1;
            r_ph   <= 1'b0;
            r_bit  <= 4'd14;
            r_q    <= '0;
            r_a2   <= i_cmd.a * i_cmd.a;
            r_s    <= i_cmd.s;
            o_done <= 1'b0;
        end else if (r_busy) begin
            if (!r_ph) begin
                r_o2   <= w_o * w_o;
                r_ph   <= 1'b1;
                o_done <= 1'b0;
            end else begin
                r_ph <= 1'b0;
                if (w_lhs <= w_rhs) r_q <= w_t;
                if (r_bit == 4'd0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_bit  <= r_bit - 4'd1;
                    o_done <= 1'b0;
                end
            end
        end else begin
            o_done <= 1'b0;
        end
    end
    assign o_q = r_q;
endmodule

### rtl/label_match_line_direction.sv
// Label match line direction: 3D segment table with label lookup.
// Load: shifts the differences down until the largest fits 15 bits, sums their
//   squares, then runs three component searches; a zero-length segment skips to
//   the result with a zero direction, and a full table drops the load.
// Query: one stored entry read per cycle.
// Clear and other requests give a single result. One item at a time; busy drops as the
// last result shows. Results are strobed by o_valid for one cycle and cannot be stalled.
// Synchronous active-low reset empties the table; memory contents are not cleared.
`timescale 1ns / 1ps
module label_match_line_direction import lmld_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_req_type,
    input  logic [15:0]        i_label,
    input  logic [15:0]        i_line_2d_index,
    input  logic signed [23:0] i_x1,
    input  logic signed [23:0] i_y1,
    input  logic signed [23:0] i_z1,
    input  logic signed [23:0] i_x2,
    input  logic signed [23:0] i_y2,
    input  logic signed [23:0] i_z2,
    output logic               o_valid,
    output logic [15:0]        o_match_2d_index,
    output logic [5:0]         o_match_3d_index,
    output logic signed [15:0] o_dir_x,
    output logic signed [15:0] o_dir_y,
    output logic signed [15:0] o_dir_z,
    output logic               o_match_valid,
    output logic               o_status,
    output logic               o_last
);
    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SHIFT = 8'b0000_0010,
        S_SQ    = 8'b0000_0100,
        S_COMP  = 8'b0000_1000,
        S_WAIT  = 8'b0001_0000,
        S_QUERY = 8'b0010_0000,
        S_FLUSH = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state r_state;
    logic [15:0] r_lab_mem [TABLE_DEPTH];
    logic [47:0] r_dir_mem [TABLE_DEPTH];
    logic [CNT_W-1:0] r_count;
    logic [15:0] r_label, r_idx2;
    logic [24:0] r_m [3];
    logic [2:0]  r_neg;
    logic [31:0] r_s;
    logic [1:0]  r_ci;
    logic [15:0] r_dir [3];
    // query walk
    logic [CNT_W-1:0] r_rd;
    logic             r_rv;
    logic [IDX_W-1:0] r_ridx;
    logic [15:0]      r_rlab;
    logic [47:0]      r_rdir;
    // pending match held back one so the last one can carry o_last
    logic             r_pv;
    logic [IDX_W-1:0] r_pidx;
    logic [47:0]      r_pdir;
    logic             n_valid;
    t_ucmd            w_cmd;
    logic             w_udone;
    logic [14:0]      w_q;
    logic [24:0]      w_d [3];
    logic [24:0]      w_mx;

    lmld_unit u_unit (.i_clk, .i_rst_n, .i_cmd(w_cmd), .o_done(w_udone), .o_q(w_q));

    always_comb begin
        w_d[0] = 25'({i_x2[23], i_x2} - {i_x1[23], i_x1});
        w_d[1] = 25'({i_y2[23], i_y2} - {i_y1[23], i_y1});
        w_d[2] = 25'({i_z2[23], i_z2} - {i_z1[23], i_z1});
        w_mx = r_m[0] | r_m[1] | r_m[2];
        w_cmd.start = (r_state == S_COMP);
        w_cmd.a = r_m[r_ci][14:0];
        w_cmd.s = r_s;
    end
    assign busy = (r_state != S_IDLE);

    always_comb begin
        case (r_state)
            S_IDLE:          n_valid = start && !(i_req_type inside {REQ_LOAD, REQ_QUERY});
            S_DONE, S_FLUSH: n_valid = 1'b1;
            S_QUERY:         n_valid = r_rv && r_rlab == r_label && r_pv;
            default:         n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_QUERY && r_rd < r_count) begin
            r_rlab <= r_lab_mem[r_rd[IDX_W-1:0]];
            r_rdir <= r_dir_mem[r_rd[IDX_W-1:0]];
            r_ridx <= r_rd[IDX_W-1:0];
        end
        if (r_state == S_DONE && r_count < CNT_W'(TABLE_DEPTH)) begin
            r_lab_mem[r_count[IDX_W-1:0]] <= r_label;
            r_dir_mem[r_count[IDX_W-1:0]] <= {r_dir[2], r_dir[1], r_dir[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_rv    <= 1'b0;
            r_pv    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (start) begin
                    r_label <= i_label;
                    r_idx2  <= i_line_2d_index;
                    if (i_req_type == REQ_LOAD) begin
                        for (int i = 0; i < 3; i++) begin
                            r_neg[i] <= w_d[i][24];
                            r_m[i]   <= w_d[i][24] ? 25'(-w_d[i]) : w_d[i];
                            r_dir[i] <= '0;
                        end
                        r_state <= (r_count >= CNT_W'(TABLE_DEPTH)) ? S_DONE : S_SHIFT;
                    end else if (i_req_type == REQ_QUERY) begin
                        r_rd    <= '0;
                        r_rv    <= 1'b0;
                        r_pv    <= 1'b0;
                        r_state <= S_QUERY;
                    end else begin
                        if (i_req_type == REQ_CLEAR) r_count <= '0;
                        o_match_2d_index <= '0;
                        o_match_3d_index <= '0;
                        o_dir_x <= '0; o_dir_y <= '0; o_dir_z <= '0;
                        o_match_valid <= 1'b0;
                        o_status <= 1'b0;
                        o_last <= 1'b1;
                    end
                end
                S_SHIFT: begin
                    // OR of magnitudes has the same top bit as the maximum
                    if (w_mx == '0) r_state <= S_DONE;
                    else if (w_mx[24:15] != '0) begin
                        for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
                    end else begin
                        r_s  <= '0;
                        r_ci <= '0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_s <= r_s + ({17'd0, r_m[r_ci][14:0]} * {17'd0, r_m[r_ci][14:0]});
                    if (r_ci == 2'd2) begin
                        r_ci <= '0;
                        r_state <= S_COMP;
                    end else r_ci <= r_ci + 2'd1;
                end
                S_COMP: r_state <= S_WAIT;
                S_WAIT: if (w_udone) begin
                    r_dir[r_ci] <= r_neg[r_ci] ? 16'(-{1'b0, w_q}) : {1'b0, w_q};
                    if (r_ci == 2'd2) r_state <= S_DONE;
                    else begin
                        r_ci <= r_ci + 2'd1;
                        r_state <= S_COMP;
                    end
                end
                S_DONE: begin
                    // a dropped load still holds the zero direction set at transfer
                    o_match_2d_index <= '0;
                    o_match_valid <= 1'b0;
                    o_last <= 1'b1;
                    o_dir_x <= r_dir[0]; o_dir_y <= r_dir[1]; o_dir_z <= r_dir[2];
                    if (r_count >= CNT_W'(TABLE_DEPTH)) begin
                        o_status <= 1'b1;
                        o_match_3d_index <= '0;
                    end else begin
                        o_status <= 1'b0;
                        o_match_3d_index <= 6'(r_count);
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_QUERY: begin
                    r_rv <= (r_rd < r_count);
                    if (r_rd < r_count) r_rd <= r_rd + 1'b1;
                    if (r_rv && r_rlab == r_label) begin
                        r_pv   <= 1'b1;
                        r_pidx <= r_ridx;
                        r_pdir <= r_rdir;
                        if (r_pv) begin
                            o_match_2d_index <= r_idx2;
                            o_match_3d_index <= 6'(r_pidx);
                            {o_dir_z, o_dir_y, o_dir_x} <= r_pdir;
                            o_match_valid <= 1'b1;
                            o_status <= 1'b0;
                            o_last <= 1'b0;
                        end
                    end
                    if (r_rd >= r_count) r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    // the final read may still be in flight
                    o_match_2d_index <= r_idx2;
                    o_status <= 1'b0;
                    r_rv <= 1'b0;
                    if (r_rv && r_rlab == r_label) begin
                        if (r_pv) begin
                            o_match_3d_index <= 6'(r_pidx);
                            {o_dir_z, o_dir_y, o_dir_x} <= r_pdir;
                            o_match_valid <= 1'b1;
                        end
                        o_last <= !r_pv;
                        r_pv   <= 1'b1;
                        r_pidx <= r_ridx;
                        r_pdir <= r_rdir;
                    end else if (r_pv) begin
                        o_match_3d_index <= 6'(r_pidx);
                        {o_dir_z, o_dir_y, o_dir_x} <= r_pdir;
                        o_match_valid <= 1'b1;
                        o_last <= 1'b1;
                        r_pv <= 1'b0;
                        r_state <= S_IDLE;
                    end else begin
                        o_match_3d_index <= '0;
                        o_dir_x <= '0; o_dir_y <= '0; o_dir_z <= '0;
                        o_match_valid <= 1'b0;
                        o_last <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/lmld_checker.sv
// Port-level checks for label_match_line_direction.
// Depends on lmld_pkg; bound to the top level below.
`timescale 1ns / 1ps
module lmld_checker import lmld_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_valid,
    input logic        o_match_valid,
    input logic        o_status,
    input logic        o_last,
    input logic [15:0] o_dir_x
);
    a_rst_idle: assert property (@(posedge i_clk) !i_rst_n |=> !busy && !o_valid)
        else $error("busy or strobe after reset");
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy || o_valid) else $error("transfer lost");
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_match_valid && o_status)) else $error("match and drop");
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_last && o_dir_x == '0) else $error("bad drop");
    a_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last |-> !busy) else $error("busy after last");
endmodule

bind label_match_line_direction lmld_checker u_chk (.*);

### tb/tb_label_match_line_direction.sv
// Testbench for label_match_line_direction: segment loads, label queries, clears and spare requests.
// Depends on lmld_pkg and the block; predicts every result and checks it in order.
`timescale 1ns / 1ps
module tb_label_match_line_direction;
    import lmld_pkg::*;

    typedef struct packed {
        logic [15:0] idx2;
        logic [5:0]  idx3;
        logic [15:0] dx;
        logic [15:0] dy;
        logic [15:0] dz;
        logic        mvalid;
        logic        status;
        logic        last;
    } t_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         i_req_type;
    logic [15:0]        i_label;
    logic [15:0]        i_line_2d_index;
    logic signed [23:0] i_x1, i_y1, i_z1, i_x2, i_y2, i_z2;
    logic               o_valid;
    logic [15:0]        o_match_2d_index;
    logic [5:0]         o_match_3d_index;
    logic signed [15:0] o_dir_x, o_dir_y, o_dir_z;
    logic               o_match_valid, o_status, o_last;

    localparam logic [1:0] REQ_SPARE = 2'd3;
    localparam int WATCHDOG_LIMIT = 20000;

    // predictor state
    logic [15:0] seg_label [TABLE_DEPTH];
    logic [47:0] seg_dir [TABLE_DEPTH];
    int          seg_count;
    t_result     pending_results[$];
    int          n_errors;
    int          idle_cycles;
    logic        test_done;
    logic [15:0] label_pool [4];

    label_match_line_direction u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_req_type(i_req_type), .i_label(i_label), .i_line_2d_index(i_line_2d_index),
        .i_x1(i_x1), .i_y1(i_y1), .i_z1(i_z1), .i_x2(i_x2), .i_y2(i_y2), .i_z2(i_z2),
        .o_valid(o_valid), .o_match_2d_index(o_match_2d_index),
        .o_match_3d_index(o_match_3d_index), .o_dir_x(o_dir_x), .o_dir_y(o_dir_y),
        .o_dir_z(o_dir_z), .o_match_valid(o_match_valid), .o_status(o_status),
        .o_last(o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // largest q with (2q-1)^2 * sum <= a^2 * 2^30
    function automatic logic [15:0] unit_component(input logic [63:0] a,
                                                   input logic [63:0] sum);
        logic [63:0] q, t, o, rhs;
        q = 0;
        rhs = (a * a) << 30;
        for (int b = 14; b >= 0; b--) begin
            t = q | (64'd1 << b);
            o = 2 * t - 1;
            if (o * o * sum <= rhs) q = t;
        end
        return q[15:0];
    endfunction

    function automatic logic [47:0] unit_direction(input logic signed [23:0] ax,
            input logic signed [23:0] ay, input logic signed [23:0] az,
            input logic signed [23:0] bx, input logic signed [23:0] by,
            input logic signed [23:0] bz);
        longint d [3];
        logic [63:0] m [3];
        logic [63:0] mx, sum;
        logic [15:0] q;
        logic [47:0] packed_dir;
        int sh;
        d[0] = longint'(bx) - longint'(ax);
        d[1] = longint'(by) - longint'(ay);
        d[2] = longint'(bz) - longint'(az);
        mx = 0;
        sum = 0;
        sh = 0;
        packed_dir = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = d[i] < 0 ? -d[i] : d[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 48'd0;
        while ((mx >> sh) >= 32768) sh++;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            sum += m[i] * m[i];
        end
        for (int i = 0; i < 3; i++) begin
            q = unit_component(m[i], sum);
            packed_dir[16*i +: 16] = d[i] < 0 ? -q : q;
        end
        return packed_dir;
    endfunction

    function automatic t_result make_result(logic [15:0] i2, logic [5:0] i3,
            logic [47:0] dir, logic mv, logic st, logic lst);
        t_result r;
        r.idx2 = i2; r.idx3 = i3;
        r.dx = dir[15:0]; r.dy = dir[31:16]; r.dz = dir[47:32];
        r.mvalid = mv; r.status = st; r.last = lst;
        return r;
    endfunction

    // append one expected result at the tail
    function automatic void add_expected(input t_result r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    task automatic predict_item(input logic [1:0] req, input logic [15:0] lab,
            input logic [15:0] i2, input logic signed [23:0] ax, ay, az, bx, by, bz);
        logic [47:0] dir;
        int hits;
        hits = 0;
        case (req)
            REQ_LOAD: begin
                if (seg_count >= TABLE_DEPTH) begin
                    add_expected(make_result(0, 0, 0, 0, 1, 1));
                end else begin
                    dir = unit_direction(ax, ay, az, bx, by, bz);
                    seg_label[seg_count] = lab;
                    seg_dir[seg_count] = dir;
                    add_expected(make_result(0, 6'(seg_count), dir, 0, 0, 1));
                    seg_count++;
                end
            end
            REQ_QUERY: begin
                for (int j = 0; j < seg_count; j++) begin
                    if (seg_label[j] == lab) begin
                        add_expected(make_result(i2, 6'(j), seg_dir[j], 1, 0, 0));
                        hits++;
                    end
                end
                if (hits == 0) add_expected(make_result(i2, 0, 0, 0, 0, 1));
                else pending_results[$].last = 1'b1;
            end
            default: begin
                if (req == REQ_CLEAR) seg_count = 0;
                add_expected(make_result(0, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    // start stays high into the next item when it follows with no gap
    task automatic send_item(input logic [1:0] req, input logic [15:0] lab,
            input logic [15:0] i2, input logic signed [23:0] ax, ay, az, bx, by, bz);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_req_type <= req; i_label <= lab; i_line_2d_index <= i2;
        i_x1 <= ax; i_y1 <= ay; i_z1 <= az; i_x2 <= bx; i_y2 <= by; i_z2 <= bz;
        // transfer happens at the first rising edge with busy low
        do @(posedge i_clk); while (busy);
        predict_item(req, lab, i2, ax, ay, az, bx, by, bz);
        @(negedge i_clk);
    endtask

    function automatic logic signed [23:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom_range(0, 15) - 8);
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic send_load(input logic [15:0] lab);
        send_item(REQ_LOAD, lab, 16'($urandom), rand_coord(), rand_coord(), rand_coord(),
                  rand_coord(), rand_coord(), rand_coord());
    endtask

    task automatic test_directed();
        send_item(REQ_QUERY, 16'd5, 16'hFFFF, 0, 0, 0, 0, 0, 0);
        send_item(REQ_LOAD, 16'd5, 16'hFFFF, 24'sd100, -24'sd7, 24'sd3,
                  24'sd100, -24'sd7, 24'sd3);
        send_item(REQ_LOAD, 16'hFFFF, 0, 24'sh800000, 24'sh800000, 24'sh800000,
                  24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(REQ_LOAD, 16'd5, 16'h1234, 24'sh7FFFFF, 0, 0, 24'sh800000, 0, 0);
        send_item(REQ_LOAD, 16'd0, 16'h0, 0, 0, 0, 0, 24'sd1, 0);
        send_item(REQ_LOAD, 16'd5, 16'h0, 0, 0, 24'sd3, 24'sd4, 0, 0);
        send_item(REQ_QUERY, 16'd5, 16'hA5A5, 0, 0, 0, 0, 0, 0);
        send_item(REQ_QUERY, 16'hFFFF, 16'h5A5A, 24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF,
                  24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
        send_item(REQ_QUERY, 16'd7, 16'h0, 0, 0, 0, 0, 0, 0);
        send_item(REQ_SPARE, 16'hFFFF, 16'hFFFF, -24'sd1, -24'sd1, -24'sd1,
                  -24'sd1, -24'sd1, -24'sd1);
        send_item(REQ_CLEAR, 16'd5, 16'd1, 0, 0, 0, 0, 0, 0);
        send_item(REQ_QUERY, 16'd5, 16'd2, 0, 0, 0, 0, 0, 0);
    endtask

    // fill to capacity with one label so a query returns the full table
    task automatic test_full_table();
        for (int k = 0; k < TABLE_DEPTH; k++) send_load(16'h00C3);
        send_load(16'h00C3);
        send_load(16'h1111);
        send_item(REQ_QUERY, 16'h00C3, 16'hBEEF, 0, 0, 0, 0, 0, 0);
        send_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int n_items);
        int pick;
        for (int k = 0; k < 4; k++) label_pool[k] = 16'($urandom);
        for (int k = 0; k < n_items; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_load($urandom_range(0, 7) == 0 ? 16'($urandom)
                          : label_pool[$urandom_range(0, 3)]);
            else if (pick < 88)
                send_item(REQ_QUERY, $urandom_range(0, 7) == 0 ? 16'($urandom)
                          : label_pool[$urandom_range(0, 3)], 16'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom));
            else if (pick < 95)
                send_item(REQ_CLEAR, 16'($urandom), 16'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
            else
                send_item(REQ_SPARE, 16'($urandom), 16'($urandom), 24'($urandom),
                          24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                          24'($urandom));
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_result got, want;
        if (i_rst_n && o_valid) begin
            got = '{o_match_2d_index, o_match_3d_index, o_dir_x, o_dir_y, o_dir_z,
                    o_match_valid, o_status, o_last};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %h", $realtime, got);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: result mismatch expected %h actual %h",
                             $realtime, want, got);
                    n_errors++;
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (!test_done && idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        n_errors = 0;
        idle_cycles = 0;
        test_done = 1'b0;
        seg_count = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_LOAD;
        i_label = 0;
        i_line_2d_index = 0;
        {i_x1, i_y1, i_z1, i_x2, i_y2, i_z2} = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed();
        test_full_table();
        test_random(380);
        start <= 1'b0;

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        test_done = 1'b1;
        if (n_errors == 0 && pending_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
